FILE: rtl/swauc_pkg.sv
// ----------------------------------------------------------------------------
// swauc_pkg
// Types and constants shared by the weighted AUC block.
// ----------------------------------------------------------------------------
`default_nettype none

package swauc_pkg;

    localparam int COUNT_BITS    = 24;
    localparam int FRACTION_BITS = 16;
    localparam int SCORE_BITS    = 32;
    localparam int WEIGHT_BITS   = 16;
    localparam int TOTAL_BITS    = 2 * COUNT_BITS + 1;
    localparam int AUC_BITS      = FRACTION_BITS + 1;

    typedef struct packed {
        logic [SCORE_BITS-1:0]  score;
        logic                   is_case;
        logic [WEIGHT_BITS-1:0] weight;
        logic                   last_item;
    } t_in_beat;

    typedef struct packed {
        logic [AUC_BITS-1:0]   auc_fraction;
        logic [TOTAL_BITS-1:0] twice_statistic;
        logic [COUNT_BITS-1:0] control_total;
        logic [COUNT_BITS-1:0] case_total;
        logic                  undefined;
        logic                  overflowed;
    } t_out_beat;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEN  = 5'b00010,
        S_CHK  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/sorted_weighted_auc_top.sv
// ----------------------------------------------------------------------------
// sorted_weighted_auc_top
// Weighted Mann-Whitney AUC over a score-sorted sample stream.
//
//  Channel | Direction | Handshake                    | Payload
//  --------+-----------+------------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_ready      | i_in_data  (t_in_beat)
//  out     | output    | o_out_valid / i_out_ready    | o_out_data (t_out_beat)
//
//  Samples are accepted back to back while idle; one multiplier, shared with the denominator
//  product, updates the doubled total on the accepting edge.
//  A last_item beat runs the denominator product, a range check and FRACTION_BITS
//  shift-subtract steps; an empty class or a ratio of at least one skips the division.
//  Input stays stalled until the result is loaded, which also waits for a held result.
//  Reset is synchronous and clears all accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_weighted_auc_top
    import swauc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_data
);

    localparam int ITER_BITS = $clog2(FRACTION_BITS);
    localparam int MUL_A     = COUNT_BITS + 1;
    localparam int PROD_BITS = MUL_A + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
    localparam logic [ITER_BITS-1:0]  ITER_LAST = ITER_BITS'(FRACTION_BITS - 1);
    localparam logic [AUC_BITS-1:0]   AUC_ONE   = AUC_BITS'(1) << FRACTION_BITS;

    t_state                r_state, n_state;
    logic [SCORE_BITS-1:0] r_last_score, n_last_score;
    logic                  r_seen, n_seen;
    logic [COUNT_BITS-1:0] r_ctrl, n_ctrl;
    logic [COUNT_BITS-1:0] r_tie, n_tie;
    logic [COUNT_BITS-1:0] r_cases, n_cases;
    logic [TOTAL_BITS-1:0] r_total, n_total;
    logic                  r_ovf, n_ovf;
    logic [TOTAL_BITS-1:0] r_den, n_den;
    logic [TOTAL_BITS-1:0] r_rem, n_rem;
    logic [AUC_BITS-1:0]   r_q, n_q;
    logic                  r_undef, n_undef;
    logic [ITER_BITS-1:0]  r_iter, n_iter;
    logic                  r_out_valid, n_out_valid;
    t_out_beat             r_out, n_out;

    logic                  accept;
    logic                  tie_hit;
    logic [COUNT_BITS-1:0] tie_used;
    logic [MUL_A-1:0]      mul_a;
    logic [COUNT_BITS-1:0] mul_b;
    logic [PROD_BITS-1:0]  prod;
    logic [TOTAL_BITS:0]   total_sum;
    logic [COUNT_BITS:0]   cases_sum;
    logic [COUNT_BITS:0]   ctrl_sum;
    logic [COUNT_BITS:0]   tie_sum;
    logic [COUNT_BITS-1:0] tie_base;
    logic                  new_score;
    logic [TOTAL_BITS:0]   rem_shift;
    logic                  out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || i_out_ready;

    assign tie_hit   = r_seen && (i_in_data.score == r_last_score);
    assign tie_used  = tie_hit ? r_tie : '0;
    assign new_score = !tie_hit;
    assign tie_base  = new_score ? '0 : r_tie;

    // shared multiplier: per-case increment, else the denominator product
    always_comb begin
        if (r_state == S_DEN) begin
            mul_a = {1'b0, r_ctrl};
            mul_b = r_cases;
        end else begin
            mul_a = {r_ctrl, 1'b0} - {1'b0, tie_used};
            mul_b = COUNT_BITS'(i_in_data.weight);
        end
    end
    assign prod = mul_a * mul_b;

    assign total_sum = {1'b0, r_total} + (TOTAL_BITS + 1)'(prod);
    assign cases_sum = {1'b0, r_cases} + (COUNT_BITS + 1)'(i_in_data.weight);
    assign ctrl_sum  = {1'b0, r_ctrl} + (COUNT_BITS + 1)'(i_in_data.weight);
    assign tie_sum   = {1'b0, tie_base} + (COUNT_BITS + 1)'(i_in_data.weight);
    assign rem_shift = {r_rem, 1'b0};

    always_comb begin
        n_state      = r_state;
        n_last_score = r_last_score;
        n_seen       = r_seen;
        n_ctrl       = r_ctrl;
        n_tie        = r_tie;
        n_cases      = r_cases;
        n_total      = r_total;
        n_ovf        = r_ovf;
        n_den        = r_den;
        n_rem        = r_rem;
        n_q          = r_q;
        n_undef      = r_undef;
        n_iter       = r_iter;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.weight != '0) begin
                        if (i_in_data.is_case) begin
                            if (total_sum > {1'b0, TOTAL_MAX}) begin
                                n_total = TOTAL_MAX;
                                n_ovf   = 1'b1;
                            end else begin
                                n_total = total_sum[TOTAL_BITS-1:0];
                            end
                            if (cases_sum[COUNT_BITS]) begin
                                n_cases = COUNT_MAX;
                                n_ovf   = 1'b1;
                            end else begin
                                n_cases = cases_sum[COUNT_BITS-1:0];
                            end
                        end else begin
                            n_last_score = i_in_data.score;
                            n_seen       = 1'b1;
                            if (tie_sum[COUNT_BITS]) begin
                                n_tie = COUNT_MAX;
                                n_ovf = 1'b1;
                            end else begin
                                n_tie = tie_sum[COUNT_BITS-1:0];
                            end
                            if (ctrl_sum[COUNT_BITS]) begin
                                n_ctrl = COUNT_MAX;
                                n_ovf  = 1'b1;
                            end else begin
                                n_ctrl = ctrl_sum[COUNT_BITS-1:0];
                            end
                        end
                    end
                    if (i_in_data.last_item) begin
                        n_state = S_DEN;
                    end
                end
            end
            S_DEN: begin
                n_den   = {prod[TOTAL_BITS-2:0], 1'b0};
                n_rem   = r_total;
                n_undef = (r_ctrl == '0) || (r_cases == '0);
                n_state = S_CHK;
            end
            S_CHK: begin
                n_iter = '0;
                if (r_undef) begin
                    n_q     = '0;
                    n_state = S_DONE;
                end else if (r_rem >= r_den) begin
                    n_q     = AUC_ONE;
                    n_state = S_DONE;
                end else begin
                    n_q     = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (rem_shift >= {1'b0, r_den}) begin
                    n_rem = TOTAL_BITS'(rem_shift - {1'b0, r_den});
                    n_q   = {r_q[AUC_BITS-2:0], 1'b1};
                end else begin
                    n_rem = rem_shift[TOTAL_BITS-1:0];
                    n_q   = {r_q[AUC_BITS-2:0], 1'b0};
                end
                n_iter = r_iter + 1'b1;
                if (r_iter == ITER_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.auc_fraction    = r_q;
                    n_out.twice_statistic = r_total;
                    n_out.control_total   = r_ctrl;
                    n_out.case_total      = r_cases;
                    n_out.undefined       = r_undef;
                    n_out.overflowed      = r_ovf;
                    n_out_valid           = 1'b1;
                    n_last_score          = '0;
                    n_seen                = 1'b0;
                    n_ctrl                = '0;
                    n_tie                 = '0;
                    n_cases               = '0;
                    n_total               = '0;
                    n_ovf                 = 1'b0;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_score <= '0;
            r_seen       <= 1'b0;
            r_ctrl       <= '0;
            r_tie        <= '0;
            r_cases      <= '0;
            r_total      <= '0;
            r_ovf        <= 1'b0;
            r_undef      <= 1'b0;
            r_iter       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_last_score <= n_last_score;
            r_seen       <= n_seen;
            r_ctrl       <= n_ctrl;
            r_tie        <= n_tie;
            r_cases      <= n_cases;
            r_total      <= n_total;
            r_ovf        <= n_ovf;
            r_undef      <= n_undef;
            r_iter       <= n_iter;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den <= n_den;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_out <= n_out;
    end

endmodule

`default_nettype wire
